/* src/mcbf_pkg.sv */
// shared types, codes and widths for the multi-channel byte fifo
`default_nettype none
package mcbf_pkg;

	localparam int MCBF_CHANNELS = 4;
	localparam int MCBF_DEPTH    = 256;

	localparam int CMD_W      = 2;
	localparam int CH_FIELD_W = 3;
	localparam int BYTE_W     = 8;
	localparam int STATUS_W   = 2;
	localparam int FILL_W     = 9;
	localparam int TALLY_W    = 10;

	localparam int TUSER_IN_W   = CMD_W + CH_FIELD_W;
	localparam int TDATA_OUT_W  = 32;
	localparam int OUT_FIELDS_W = BYTE_W + FILL_W + TALLY_W;
	localparam int OUT_PAD_W    = TDATA_OUT_W - OUT_FIELDS_W;

	localparam logic [TALLY_W-1:0] TALLY_MAX = 10'd1023;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_CH  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd2;

	typedef struct packed {
		logic capture;
		logic execute;
		logic load_out;
	} dp_cmd_t;

endpackage
`default_nettype wire

/* src/mcbf_ctrl.sv */
// sequencing state machine: capture, execute, output load
`default_nettype none
module mcbf_ctrl
	import mcbf_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output dp_cmd_t      dp_cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   load_ok;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load_ok   = !out_valid_q || out_ready;

	always_comb begin
		dp_cmd.capture  = in_valid && in_ready;
		dp_cmd.execute  = (state_q == S_EXEC);
		dp_cmd.load_out = (state_q == S_LOAD) && load_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (dp_cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (load_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/mcbf_dpath.sv */
// datapath: byte store, ring pointers, occupancy, tally and result registers
`default_nettype none
module mcbf_dpath
	import mcbf_pkg::*;
#(
	parameter int CHANNELS = MCBF_CHANNELS,
	parameter int DEPTH    = MCBF_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dp_cmd_t               dp_cmd,
	input  wire logic [CMD_W-1:0]      in_cmd,
	input  wire logic [CH_FIELD_W-1:0] in_channel,
	input  wire logic [BYTE_W-1:0]     in_wr_byte,
	input  wire logic                  in_req_last,
	output logic [STATUS_W-1:0]        status,
	output logic [BYTE_W-1:0]          rd_byte,
	output logic [FILL_W-1:0]          fill_level,
	output logic [TALLY_W-1:0]         moved_total,
	output logic                       total_valid
);

	localparam int PTR_W     = $clog2(DEPTH);
	localparam int OCC_W     = $clog2(DEPTH + 1);
	localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CH_CMP_W  = CH_FIELD_W + 1;
	localparam int MEM_DEPTH = CHANNELS * DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam logic [PTR_W-1:0]    PTR_LAST   = PTR_W'(DEPTH - 1);
	localparam logic [OCC_W-1:0]    OCC_FULL   = OCC_W'(DEPTH);
	localparam logic [CH_CMP_W-1:0] CH_LIMIT   = CH_CMP_W'(CHANNELS);
	localparam logic [ADDR_W-1:0]   ADDR_DEPTH = ADDR_W'(DEPTH);

	// captured beat
	logic [CMD_W-1:0]      cmd_q;
	logic [CH_FIELD_W-1:0] ch_q;
	logic [BYTE_W-1:0]     wb_q;
	logic                  last_q;

	// per-channel ring state and shared tally
	logic [PTR_W-1:0] wp_q  [CHANNELS];
	logic [PTR_W-1:0] rp_q  [CHANNELS];
	logic [OCC_W-1:0] occ_q [CHANNELS];
	logic [TALLY_W-1:0] tally_q;

	logic [BYTE_W-1:0] mem [MEM_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	// execute results
	logic [STATUS_W-1:0] res_status_q;
	logic                res_rd_ok_q;
	logic [FILL_W-1:0]   res_fill_q;
	logic [TALLY_W-1:0]  res_moved_q;
	logic                res_last_q;

	// output register
	logic [STATUS_W-1:0] out_status_q;
	logic [BYTE_W-1:0]   out_rd_q;
	logic [FILL_W-1:0]   out_fill_q;
	logic [TALLY_W-1:0]  out_moved_q;
	logic                out_last_q;

	logic [CH_IDX_W-1:0] idx;
	logic                ch_ok;
	logic [OCC_W-1:0]    occ_cur;
	logic [OCC_W-1:0]    occ_next;
	logic [PTR_W-1:0]    wp_cur;
	logic [PTR_W-1:0]    rp_cur;
	logic [PTR_W-1:0]    wp_next;
	logic [PTR_W-1:0]    rp_next;
	logic                is_full;
	logic                is_empty;
	logic                do_clr;
	logic                do_wr;
	logic                do_rd;
	logic [STATUS_W-1:0] status_next;
	logic [FILL_W-1:0]   fill_next;
	logic [TALLY_W-1:0]  moved_next;
	logic [ADDR_W-1:0]   base_addr;
	logic [ADDR_W-1:0]   mem_addr;

	always_comb begin
		idx      = ch_q[CH_IDX_W-1:0];
		ch_ok    = {1'b0, ch_q} < CH_LIMIT;
		occ_cur  = occ_q[idx];
		wp_cur   = wp_q[idx];
		rp_cur   = rp_q[idx];
		wp_next  = (wp_cur == PTR_LAST) ? '0 : wp_cur + 1'b1;
		rp_next  = (rp_cur == PTR_LAST) ? '0 : rp_cur + 1'b1;
		is_full  = (occ_cur == OCC_FULL);
		is_empty = (occ_cur == '0);
		do_clr   = ch_ok && (cmd_q == CMD_CLEAR);
		do_wr    = ch_ok && (cmd_q == CMD_WRITE) && !is_full;
		do_rd    = ch_ok && (cmd_q == CMD_READ) && !is_empty;

		if (!ch_ok) begin
			status_next = ST_BAD_CH;
		end else if (((cmd_q == CMD_WRITE) && is_full) || ((cmd_q == CMD_READ) && is_empty)) begin
			status_next = ST_NO_ROOM;
		end else begin
			status_next = ST_DONE;
		end

		if (do_clr) begin
			occ_next = '0;
		end else if (do_wr) begin
			occ_next = occ_cur + 1'b1;
		end else if (do_rd) begin
			occ_next = occ_cur - 1'b1;
		end else begin
			occ_next = occ_cur;
		end
		fill_next = ch_ok ? FILL_W'(occ_next) : '0;

		if ((do_wr || do_rd) && (tally_q != TALLY_MAX)) begin
			moved_next = tally_q + 1'b1;
		end else begin
			moved_next = tally_q;
		end

		base_addr = ADDR_W'(ADDR_W'(idx) * ADDR_DEPTH);
		mem_addr  = base_addr + ADDR_W'(do_wr ? wp_cur : rp_cur);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				wp_q[i]  <= '0;
				rp_q[i]  <= '0;
				occ_q[i] <= '0;
			end
			tally_q <= '0;
		end else if (dp_cmd.execute) begin
			if (ch_ok) begin
				occ_q[idx] <= occ_next;
			end
			if (do_clr) begin
				wp_q[idx] <= '0;
				rp_q[idx] <= '0;
			end
			if (do_wr) begin
				wp_q[idx] <= wp_next;
			end
			if (do_rd) begin
				rp_q[idx] <= rp_next;
			end
			tally_q <= last_q ? '0 : moved_next;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.execute && do_wr) begin
			mem[mem_addr] <= wb_q;
		end
		if (dp_cmd.execute) begin
			rd_data_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			cmd_q  <= in_cmd;
			ch_q   <= in_channel;
			wb_q   <= in_wr_byte;
			last_q <= in_req_last;
		end
		if (dp_cmd.execute) begin
			res_status_q <= status_next;
			res_rd_ok_q  <= do_rd;
			res_fill_q   <= fill_next;
			res_moved_q  <= moved_next;
			res_last_q   <= last_q;
		end
		if (dp_cmd.load_out) begin
			out_status_q <= res_status_q;
			out_rd_q     <= res_rd_ok_q ? rd_data_q : '0;
			out_fill_q   <= res_fill_q;
			out_moved_q  <= res_moved_q;
			out_last_q   <= res_last_q;
		end
	end

	assign status      = out_status_q;
	assign rd_byte     = out_rd_q;
	assign fill_level  = out_fill_q;
	assign moved_total = out_moved_q;
	assign total_valid = out_last_q;

endmodule
`default_nettype wire

/* src/multi_channel_byte_fifo.sv */
// top level: bank of per-channel byte ring buffers behind stream ports
// result path: input beat is captured, executed, then loaded into the output register
// input: a new beat is taken only in the idle state, after the execute and load states
//   of the controller have passed for the last one; a waiting result stalls the next load
// reset: arst_n clears pointers, fill counts, tally and handshake state at once;
//   the byte store is not cleared, no sweep is needed
`default_nettype none
module multi_channel_byte_fifo
	import mcbf_pkg::*;
#(
	parameter int CHANNELS = MCBF_CHANNELS,
	parameter int DEPTH    = MCBF_DEPTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [BYTE_W-1:0]      s_axis_tdata,  // wr_byte
	input  wire logic [TUSER_IN_W-1:0]  s_axis_tuser,  // cmd, channel
	input  wire logic                   s_axis_tlast,  // req_last
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [TDATA_OUT_W-1:0]      m_axis_tdata,  // rd_byte, fill_level, moved_total, zero pad
	output logic [STATUS_W-1:0]         m_axis_tuser,  // status
	output logic                        m_axis_tlast   // total_valid
);

	dp_cmd_t             dp_cmd;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   rd_byte;
	logic [FILL_W-1:0]   fill_level;
	logic [TALLY_W-1:0]  moved_total;
	logic                total_valid;

	mcbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.dp_cmd    (dp_cmd)
	);

	mcbf_dpath #(
		.CHANNELS (CHANNELS),
		.DEPTH    (DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.in_cmd      (s_axis_tuser[CMD_W-1:0]),
		.in_channel  (s_axis_tuser[TUSER_IN_W-1:CMD_W]),
		.in_wr_byte  (s_axis_tdata),
		.in_req_last (s_axis_tlast),
		.status      (status),
		.rd_byte     (rd_byte),
		.fill_level  (fill_level),
		.moved_total (moved_total),
		.total_valid (total_valid)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, moved_total, fill_level, rd_byte};
	assign m_axis_tuser = status;
	assign m_axis_tlast = total_valid;

	// one beat in flight: no second capture straight after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while a beat is still in execute");

	// a new result only appears after the output load command
	a_load_before_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(dp_cmd.load_out))
		else $error("result valid without an output load");

	// a bad channel reports nothing held and nothing read
	a_bad_channel_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == ST_BAD_CH)) |->
		((m_axis_tdata[BYTE_W-1:0] == '0) &&
		 (m_axis_tdata[BYTE_W+FILL_W-1:BYTE_W] == '0)))
		else $error("bad channel result carries data");

	// reported fill never exceeds the channel depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(m_axis_tdata[BYTE_W+FILL_W-1:BYTE_W]) <= 32'(DEPTH)))
		else $error("fill level above depth");

endmodule
`default_nettype wire
